// ===== design/rsar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsar_pkg;

	// Fixed field widths of the item and configuration formats.
	localparam int ATTR_BITS = 16;
	localparam int LEN_BITS  = 5;
	localparam int PCT_BITS  = 7;
	localparam int CMD_BITS  = 2;
	localparam int WID_BITS  = 32;
	localparam int REG_BITS  = 3;
	localparam int NUM_ATTR  = 3;

	localparam int unsigned PCT_FULL  = 100;
	localparam int unsigned ATTR_FULL = 65535;

	// Full scale split as whole steps per percent plus a remainder per percent.
	localparam int unsigned ATTR_STEP = ATTR_FULL / PCT_FULL;
	localparam int unsigned ATTR_REM  = ATTR_FULL % PCT_FULL;
	// Reciprocal of one hundred as 1311 / 2^17, exact for numerators up to 3500.
	localparam int unsigned PCT_RECIP       = 1311;
	localparam int unsigned PCT_RECIP_SHIFT = 17;

	// Item command codes.
	localparam logic [CMD_BITS-1:0] CMD_FOCUS  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_BITS-1:0] REG_LIST_LENGTH = 3'd0;
	localparam logic [REG_BITS-1:0] REG_RAMP_START  = 3'd1;
	localparam logic [REG_BITS-1:0] REG_MIN_OPACITY = 3'd2;
	localparam logic [REG_BITS-1:0] REG_MAX_OPACITY = 3'd3;
	localparam logic [REG_BITS-1:0] REG_MIN_BRIGHT  = 3'd4;
	localparam logic [REG_BITS-1:0] REG_MAX_BRIGHT  = 3'd5;
	localparam logic [REG_BITS-1:0] REG_MIN_SAT     = 3'd6;
	localparam logic [REG_BITS-1:0] REG_MAX_SAT     = 3'd7;

	// Register values after reset.
	localparam logic [LEN_BITS-1:0] RST_LIST_LENGTH = 5'd5;
	localparam logic [LEN_BITS-1:0] RST_RAMP_START  = 5'd1;
	localparam logic [PCT_BITS-1:0] RST_MIN_OPACITY = 7'd70;
	localparam logic [PCT_BITS-1:0] RST_MAX_OPACITY = 7'd100;
	localparam logic [PCT_BITS-1:0] RST_MIN_BRIGHT  = 7'd90;
	localparam logic [PCT_BITS-1:0] RST_MAX_BRIGHT  = 7'd100;
	localparam logic [PCT_BITS-1:0] RST_MIN_SAT     = 7'd100;
	localparam logic [PCT_BITS-1:0] RST_MAX_SAT     = 7'd100;

	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic [WID_BITS-1:0] window_id;
		logic                eligible;
	} in_item_t;

	typedef struct packed {
		logic                 applies;
		logic [LEN_BITS-1:0]  position;
		logic [ATTR_BITS-1:0] opacity;
		logic [ATTR_BITS-1:0] brightness;
		logic [ATTR_BITS-1:0] saturation;
		logic                 moved;
	} out_item_t;

	// What the list has to do for the item that was loaded.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_ROLL,
		OP_PACK,
		OP_FIND
	} op_t;

	// Per-cycle command from the controller to the list datapath.
	typedef enum logic [2:0] {
		LC_IDLE,
		LC_LOAD,
		LC_ROLL,
		LC_PACK,
		LC_FILL,
		LC_FIND
	} lcmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OPSEL,
		ST_ROLL,
		ST_PACK,
		ST_FILL,
		ST_FIND,
		ST_DIVW,
		ST_MUL,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		op_t  op;
		logic last;
		logic fill_needed;
	} list_sts_t;

	typedef struct packed {
		logic                applies;
		logic                moved;
		logic [LEN_BITS-1:0] pos;
	} list_res_t;

	typedef struct packed {
		logic start;
		logic mul;
		logic load;
	} ramp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} ramp_sts_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]                n;
		logic [LEN_BITS-1:0]                start_pos;
		logic [LEN_BITS-1:0]                span;
		logic [NUM_ATTR-1:0][PCT_BITS-1:0]  pct_min;
		logic [NUM_ATTR-1:0][PCT_BITS-1:0]  pct_max;
	} ramp_cfg_t;

	// Percent to full-scale attribute, saturating above one hundred percent.
	// The product p*65535/100 is formed as p*655 plus the truncated p*35/100.
	function automatic logic [ATTR_BITS-1:0] pct_scale(input logic [PCT_BITS-1:0] p);
		logic [PCT_BITS-1:0] ps;
		logic [11:0]         rest;
		logic [22:0]         rest_q;
		ps     = (p > PCT_BITS'(PCT_FULL)) ? PCT_BITS'(PCT_FULL) : p;
		rest   = 12'(ps) * 12'(ATTR_REM);
		rest_q = 23'(rest) * 23'(PCT_RECIP);
		return ATTR_BITS'(16'(ps) * 16'(ATTR_STEP) + 16'(rest_q >> PCT_RECIP_SHIFT));
	endfunction

endpackage

`default_nettype wire

// ===== design/recency_stack_attribute_ramp_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: an accepted item starts the 16-step ramp dividers and is loaded into the list,
// which is walked as needed; the step is then scaled by the position and emitted.
// A focus walks up to list_length+1 slots, a query up to list_length, and a remove
// that compacts and zero-fills the list up to 2*list_length.
// Input: the next item is taken only once the previous result is in the output register.
// Reset: asynchronous, active low; registers return to their defaults and the list
// is cleared at once, with no clearing pass.

module recency_stack_attribute_ramp_top
	import rsar_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int ID_BITS     = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_item,
	input  logic                cfg_wr_en,
	input  logic [REG_BITS-1:0] cfg_addr,
	input  logic [PCT_BITS-1:0] cfg_wdata
);

	// The list length register cannot name more slots than its field holds, so the
	// stored list never needs more than that many entries plus the overflow slot.
	localparam int LEN_CAP   = (1 << LEN_BITS) - 1;
	localparam int MAX_LEN_I = (MAX_ENTRIES > LEN_CAP) ? LEN_CAP : MAX_ENTRIES;
	localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_LEN_I);
	localparam int DEPTH = MAX_LEN_I + 1;
	// Ids wider than the item field carry zeros in their upper bits, so they are not stored.
	localparam int ID_W = (ID_BITS < WID_BITS) ? ID_BITS : WID_BITS;

	logic [LEN_BITS-1:0]               len_q;
	logic [LEN_BITS-1:0]               start_q;
	logic [NUM_ATTR-1:0][PCT_BITS-1:0] pct_min_q;
	logic [NUM_ATTR-1:0][PCT_BITS-1:0] pct_max_q;

	logic [LEN_BITS-1:0] n;
	logic [LEN_BITS-1:0] rs;
	logic [LEN_BITS-1:0] rs_m1;
	logic [LEN_BITS-1:0] start_pos;

	list_sts_t lsts;
	list_res_t lres;
	ramp_sts_t rsts;
	ramp_cmd_t rcmd;
	ramp_cfg_t rcfg;
	lcmd_t     lcmd;

	// Configuration register file. Writes must arrive only while no item is in flight;
	// the block does not enforce this, and the list and ramp logic read these registers directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= RST_LIST_LENGTH;
			start_q      <= RST_RAMP_START;
			pct_min_q[0] <= RST_MIN_OPACITY;
			pct_max_q[0] <= RST_MAX_OPACITY;
			pct_min_q[1] <= RST_MIN_BRIGHT;
			pct_max_q[1] <= RST_MAX_BRIGHT;
			pct_min_q[2] <= RST_MIN_SAT;
			pct_max_q[2] <= RST_MAX_SAT;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_LIST_LENGTH: len_q        <= cfg_wdata[LEN_BITS-1:0];
				REG_RAMP_START:  start_q      <= cfg_wdata[LEN_BITS-1:0];
				REG_MIN_OPACITY: pct_min_q[0] <= cfg_wdata;
				REG_MAX_OPACITY: pct_max_q[0] <= cfg_wdata;
				REG_MIN_BRIGHT:  pct_min_q[1] <= cfg_wdata;
				REG_MAX_BRIGHT:  pct_max_q[1] <= cfg_wdata;
				REG_MIN_SAT:     pct_min_q[2] <= cfg_wdata;
				REG_MAX_SAT:     pct_max_q[2] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Effective list length and ramp start. Zero acts as one for either; a length
	// past the table is cut to its size; a start past the list goes to the last tracked slot.
	always_comb begin
		if (len_q == '0) begin
			n = LEN_BITS'(1);
		end else if (len_q > MAX_LEN) begin
			n = MAX_LEN;
		end else begin
			n = len_q;
		end
		rs        = (start_q == '0) ? LEN_BITS'(1) : start_q;
		rs_m1     = rs - LEN_BITS'(1);
		start_pos = (rs_m1 >= n) ? n - LEN_BITS'(1) : rs_m1;
	end

	assign rcfg.n         = n;
	assign rcfg.start_pos = start_pos;
	assign rcfg.span      = n - start_pos;
	assign rcfg.pct_min   = pct_min_q;
	assign rcfg.pct_max   = pct_max_q;

	// The controller sequences each item: load, the list walk if one is needed, wait for
	// the ramp step, scale it by the position, and hand the result to the output register.
	rsar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.lsts     (lsts),
		.rsts     (rsts),
		.lcmd     (lcmd),
		.rcmd     (rcmd)
	);

	// Recency list: one slot is read and at most one written per cycle.
	rsar_list #(
		.DEPTH (DEPTH),
		.ID_W  (ID_W)
	) u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.lcmd    (lcmd),
		.in_item (in_item),
		.n       (n),
		.sts     (lsts),
		.res     (lres)
	);

	// Ramp dividers, position multiply and the output register. The output register
	// decouples the result from the input side, so a new item may be taken while
	// the previous result is still stalled.
	rsar_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rcmd      (rcmd),
		.cfg       (rcfg),
		.res       (lres),
		.out_stall (out_stall),
		.sts       (rsts),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== design/rsar_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsar_list
	import rsar_pkg::*;
#(
	parameter int DEPTH = 17,
	parameter int ID_W  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lcmd_t               lcmd,
	input  in_item_t            in_item,
	input  logic [LEN_BITS-1:0] n,
	output list_sts_t           sts,
	output list_res_t           res
);

	localparam int IW = $clog2(DEPTH);

	logic [ID_W-1:0]     list_q [DEPTH];
	logic [ID_W-1:0]     id_q;
	logic [ID_W-1:0]     carry_q;
	logic [ID_W-1:0]     cur;
	logic [ID_W-1:0]     in_id;
	logic [LEN_BITS-1:0] rd_q;
	logic [LEN_BITS-1:0] wr_q;
	logic [LEN_BITS-1:0] wr_nx;
	logic [LEN_BITS-1:0] pos_q;
	op_t                 op_q;
	op_t                 in_op;
	logic                applies_q;
	logic                moved_q;
	logic                hit;
	logic [IW-1:0]       rd_idx;
	logic [IW-1:0]       wr_idx;

	assign in_id  = in_item.window_id[ID_W-1:0];
	assign rd_idx = rd_q[IW-1:0];
	assign wr_idx = wr_q[IW-1:0];
	assign cur    = list_q[rd_idx];
	assign hit    = (cur == id_q);
	assign wr_nx  = hit ? wr_q : wr_q + LEN_BITS'(1);

	always_comb begin
		if (in_id == '0) begin
			in_op = OP_NONE;
		end else if (in_item.cmd == CMD_FOCUS && in_item.eligible) begin
			in_op = OP_ROLL;
		end else if (in_item.cmd == CMD_REMOVE) begin
			in_op = OP_PACK;
		end else begin
			in_op = OP_FIND;
		end
	end

	always_comb begin
		sts.op          = op_q;
		sts.fill_needed = (wr_nx != n);
		unique case (lcmd)
			LC_ROLL: sts.last = (rd_q == n) || hit;
			LC_PACK: sts.last = (rd_q == n - LEN_BITS'(1));
			LC_FILL: sts.last = (wr_q == n - LEN_BITS'(1));
			LC_FIND: sts.last = hit || (rd_q == n - LEN_BITS'(1));
			LC_IDLE, LC_LOAD: sts.last = 1'b0;
			default: sts.last = 1'b0;
		endcase
	end

	assign res.applies = applies_q;
	assign res.moved   = moved_q;
	assign res.pos     = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				list_q[i] <= '0;
			end
			rd_q      <= '0;
			wr_q      <= '0;
			op_q      <= OP_NONE;
			applies_q <= 1'b0;
			moved_q   <= 1'b0;
			pos_q     <= '0;
			id_q      <= '0;
			carry_q   <= '0;
		end else begin
			unique case (lcmd)
				LC_LOAD: begin
					rd_q      <= '0;
					wr_q      <= '0;
					id_q      <= in_id;
					carry_q   <= in_id;
					op_q      <= in_op;
					applies_q <= in_item.eligible && (in_id != '0);
					moved_q   <= 1'b0;
					pos_q     <= (in_op == OP_ROLL) ? '0 : n;
				end
				LC_ROLL: begin
					// Each slot takes the id above it until the old copy is overwritten.
					list_q[rd_idx] <= carry_q;
					carry_q        <= cur;
					rd_q           <= rd_q + LEN_BITS'(1);
					if ((rd_q == n) || hit) begin
						moved_q <= (rd_q != '0);
					end
				end
				LC_PACK: begin
					if (!hit) begin
						list_q[wr_idx] <= cur;
					end
					wr_q <= wr_nx;
					rd_q <= rd_q + LEN_BITS'(1);
				end
				LC_FILL: begin
					list_q[wr_idx] <= '0;
					wr_q           <= wr_q + LEN_BITS'(1);
				end
				LC_FIND: begin
					if (hit) begin
						pos_q <= rd_q;
					end
					rd_q <= rd_q + LEN_BITS'(1);
				end
				LC_IDLE: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/rsar_ramp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsar_ramp
	import rsar_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ramp_cmd_t rcmd,
	input  ramp_cfg_t cfg,
	input  list_res_t res,
	input  logic      out_stall,
	output ramp_sts_t sts,
	output logic      out_valid,
	output out_item_t out_item
);

	localparam int CNT_BITS = $clog2(ATTR_BITS);
	localparam int PROD_BITS = ATTR_BITS + LEN_BITS;

	logic [ATTR_BITS-1:0] mn_w   [NUM_ATTR];
	logic [ATTR_BITS-1:0] mx_w   [NUM_ATTR];
	logic [ATTR_BITS-1:0] diff_w [NUM_ATTR];
	logic [ATTR_BITS-1:0] attr   [NUM_ATTR];
	logic [PROD_BITS-1:0] prod   [NUM_ATTR];
	logic [LEN_BITS:0]    trial  [NUM_ATTR];
	logic [ATTR_BITS-1:0] mx_q   [NUM_ATTR];
	logic [ATTR_BITS-1:0] quo_q  [NUM_ATTR];
	logic [ATTR_BITS-1:0] d_q    [NUM_ATTR];
	logic [LEN_BITS-1:0]  rem_q  [NUM_ATTR];
	logic [NUM_ATTR-1:0]  down_q;
	logic [LEN_BITS:0]    span_x;
	logic [LEN_BITS-1:0]  dpos;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 inr_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	assign span_x = {1'b0, cfg.span};
	assign dpos   = res.pos - cfg.start_pos;

	always_comb begin
		for (int a = 0; a < NUM_ATTR; a++) begin
			mn_w[a]   = pct_scale(cfg.pct_min[a]);
			mx_w[a]   = pct_scale(cfg.pct_max[a]);
			diff_w[a] = (mx_w[a] >= mn_w[a]) ? mx_w[a] - mn_w[a] : mn_w[a] - mx_w[a];
			trial[a]  = {rem_q[a], quo_q[a][ATTR_BITS-1]};
			prod[a]   = PROD_BITS'(quo_q[a]) * PROD_BITS'(dpos);
			if (!res.applies) begin
				attr[a] = '0;
			end else if (!inr_q) begin
				attr[a] = mx_q[a];
			end else if (down_q[a]) begin
				attr[a] = mx_q[a] - d_q[a];
			end else begin
				attr[a] = mx_q[a] + d_q[a];
			end
		end
	end

	assign sts.div_done = !busy_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_item     = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rcmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
				end
			end
			if (rcmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Three restoring dividers run side by side, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_ATTR; a++) begin
			if (rcmd.start) begin
				mx_q[a]   <= mx_w[a];
				down_q[a] <= (mx_w[a] >= mn_w[a]);
				quo_q[a]  <= diff_w[a];
				rem_q[a]  <= '0;
			end else if (busy_q) begin
				if (trial[a] >= span_x) begin
					rem_q[a] <= LEN_BITS'(trial[a] - span_x);
					quo_q[a] <= {quo_q[a][ATTR_BITS-2:0], 1'b1};
				end else begin
					rem_q[a] <= trial[a][LEN_BITS-1:0];
					quo_q[a] <= {quo_q[a][ATTR_BITS-2:0], 1'b0};
				end
			end
			if (rcmd.mul) begin
				d_q[a] <= prod[a][ATTR_BITS-1:0];
			end
		end
		if (rcmd.mul) begin
			inr_q <= (res.pos >= cfg.start_pos);
		end
		if (rcmd.load) begin
			out_item_q.applies    <= res.applies;
			out_item_q.position   <= res.pos;
			out_item_q.opacity    <= attr[0];
			out_item_q.brightness <= attr[1];
			out_item_q.saturation <= attr[2];
			out_item_q.moved      <= res.moved;
		end
	end

	a_mul_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		rcmd.mul |-> sts.div_done)
		else $error("ramp step used before the division finished");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		rcmd.load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	a_zero_attr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_item_q.applies) |->
		(out_item_q.opacity == '0 && out_item_q.brightness == '0 &&
		 out_item_q.saturation == '0))
		else $error("attributes nonzero for an item that does not apply");

	a_moved_front: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.moved) |->
		(out_item_q.position == '0 && out_item_q.applies))
		else $error("moved item not reported at the front");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.position <= cfg.n))
		else $error("position beyond list length");

endmodule

`default_nettype wire

// ===== design/rsar_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsar_ctrl
	import rsar_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  list_sts_t lsts,
	input  ramp_sts_t rsts,
	output lcmd_t     lcmd,
	output ramp_cmd_t rcmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_OPSEL;
				end
			end
			ST_OPSEL: begin
				unique case (lsts.op)
					OP_ROLL: state_d = ST_ROLL;
					OP_PACK: state_d = ST_PACK;
					OP_FIND: state_d = ST_FIND;
					OP_NONE: state_d = ST_DIVW;
					default: state_d = ST_DIVW;
				endcase
			end
			ST_ROLL, ST_FILL, ST_FIND: begin
				if (lsts.last) begin
					state_d = ST_DIVW;
				end
			end
			ST_PACK: begin
				if (lsts.last) begin
					state_d = lsts.fill_needed ? ST_FILL : ST_DIVW;
				end
			end
			ST_DIVW: begin
				if (rsts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (rsts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		lcmd     = LC_IDLE;
		rcmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					lcmd       = LC_LOAD;
					rcmd.start = 1'b1;
				end
			end
			ST_ROLL: lcmd = LC_ROLL;
			ST_PACK: lcmd = LC_PACK;
			ST_FILL: lcmd = LC_FILL;
			ST_FIND: lcmd = LC_FIND;
			ST_MUL:  rcmd.mul = 1'b1;
			ST_EMIT: rcmd.load = rsts.out_free;
			ST_OPSEL, ST_DIVW: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/sv/recency_stack_attribute_ramp_top_tb.sv =====
`timescale 1ns / 1ps

module recency_stack_attribute_ramp_top_tb;
	import rsar_pkg::*;

	localparam int unsigned SLOTS          = 16;
	localparam int unsigned POOL_SIZE      = 20;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// Allowance at the end of the run for a remove on the longest list to finish.
	localparam int unsigned TAIL_CYCLES    = 40;
	localparam int unsigned MAX_PRINTED    = 40;

	// The block treats the unused command code as a query.
	localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                cfg_wr_en = 1'b0;
	logic [REG_BITS-1:0] cfg_addr  = '0;
	logic [PCT_BITS-1:0] cfg_wdata = '0;

	recency_stack_attribute_ramp_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Items waiting to be offered, and the results predicted for accepted items.
	in_item_t    pending_items [$];
	out_item_t   predicted_results [$];

	// Shadow of the block: register values as stored, the recency list with its
	// overflow slot at the end, and the attribute ramp derived from the registers.
	int unsigned shadow_regs [8];
	logic [31:0] recency [SLOTS+1];
	logic [15:0] ramp [SLOTS+1][NUM_ATTR];

	logic [31:0] id_pool [POOL_SIZE];

	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned holds_asked    = 0;
	int unsigned holds_done;
	int unsigned hold_left;
	int unsigned mismatches     = 0;
	int unsigned results_seen   = 0;
	int unsigned quiet_cycles   = 0;

	// Effective list length: zero counts as one, anything past the table as the table size.
	function automatic int unsigned list_len();
		int unsigned n;
		n = shadow_regs[REG_LIST_LENGTH];
		if (n < 1) n = 1;
		if (n > SLOTS) n = SLOTS;
		return n;
	endfunction

	function automatic int unsigned pct_to_attr(int unsigned p);
		if (p > PCT_FULL) p = PCT_FULL;
		return (p * ATTR_FULL) / PCT_FULL;
	endfunction

	// Positions before the ramp start hold the maximum. From there each position
	// moves toward the minimum by a truncated step, up to and including the
	// "absent" position at the list length. Past that the maximum returns.
	function automatic void rebuild_ramp();
		int unsigned n, rs, first, span, lo, hi, stp, d, v;
		bit          falls;
		n  = list_len();
		rs = shadow_regs[REG_RAMP_START];
		if (rs < 1) rs = 1;
		first = (rs - 1 >= n) ? n - 1 : rs - 1;
		span  = n - first;
		for (int a = 0; a < NUM_ATTR; a++) begin
			case (a)
				0: begin
					lo = pct_to_attr(shadow_regs[REG_MIN_OPACITY]);
					hi = pct_to_attr(shadow_regs[REG_MAX_OPACITY]);
				end
				1: begin
					lo = pct_to_attr(shadow_regs[REG_MIN_BRIGHT]);
					hi = pct_to_attr(shadow_regs[REG_MAX_BRIGHT]);
				end
				default: begin
					lo = pct_to_attr(shadow_regs[REG_MIN_SAT]);
					hi = pct_to_attr(shadow_regs[REG_MAX_SAT]);
				end
			endcase
			falls = (hi >= lo);
			stp   = (falls ? hi - lo : lo - hi) / span;
			for (int i = 0; i <= SLOTS; i++) begin
				v = hi;
				if (i >= first && i <= n) begin
					d = stp * (i - first);
					v = falls ? hi - d : hi + d;
				end
				ramp[i][a] = v[15:0];
			end
		end
	endfunction

	function automatic int unsigned locate(logic [31:0] id, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			if (recency[i] == id) return i;
		return n;
	endfunction

	// Applies one accepted item to the shadow list and returns the result it must give.
	function automatic out_item_t apply_window_item(in_item_t it);
		out_item_t   r;
		int unsigned n, p, w;
		logic        moved;
		logic [31:0] id;
		n     = list_len();
		id    = it.window_id;
		moved = 1'b0;
		if (it.cmd == CMD_FOCUS && id != 0 && it.eligible) begin
			p = locate(id, n);
			if (p != 0) begin
				// An absent id comes in at the front and pushes the last entry
				// into the overflow slot.
				for (int unsigned i = p; i > 0; i--) recency[i] = recency[i-1];
				recency[0] = id;
				moved = 1'b1;
			end
		end else if (it.cmd == CMD_REMOVE && id != 0) begin
			// Every copy inside the list goes; the overflow slot is left alone.
			w = 0;
			for (int unsigned i = 0; i < n; i++)
				if (recency[i] != id) begin
					recency[w] = recency[i];
					w++;
				end
			while (w < n) begin
				recency[w] = '0;
				w++;
			end
		end
		p = (id != 0) ? locate(id, n) : n;
		r.applies    = it.eligible && (id != 0);
		r.position   = p[LEN_BITS-1:0];
		r.opacity    = r.applies ? ramp[p][0] : '0;
		r.brightness = r.applies ? ramp[p][1] : '0;
		r.saturation = r.applies ? ramp[p][2] : '0;
		r.moved      = moved;
		return r;
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns: result %0d %s: got %0h, expected %0h",
				$time, results_seen, what, got, want);
		mismatches++;
	endtask

	// Sender. A held item stays on the bus until it is taken; after each take the
	// next item may follow at once or after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && !in_stall)
				predicted_results.push_back(apply_window_item(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_item  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall. A hold request from the stimulus keeps the output blocked
	// for a long stretch so that the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				log_mismatch("arrived with nothing outstanding", 32'(out_item.position), '0);
			end else begin
				want = predicted_results.pop_front();
				if (out_item.applies !== want.applies)
					log_mismatch("applies", 32'(out_item.applies), 32'(want.applies));
				if (out_item.position !== want.position)
					log_mismatch("position", 32'(out_item.position), 32'(want.position));
				if (out_item.opacity !== want.opacity)
					log_mismatch("opacity", 32'(out_item.opacity), 32'(want.opacity));
				if (out_item.brightness !== want.brightness)
					log_mismatch("brightness", 32'(out_item.brightness),
						32'(want.brightness));
				if (out_item.saturation !== want.saturation)
					log_mismatch("saturation", 32'(out_item.saturation),
						32'(want.saturation));
				if (out_item.moved !== want.moved)
					log_mismatch("moved", 32'(out_item.moved), 32'(want.moved));
			end
			results_seen++;
		end
	end

	// Watchdog: ends the run when neither side nor the register port has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL recency_stack_attribute_ramp_top");
			$finish;
		end
	end

	function automatic void offer(input logic [CMD_BITS-1:0] c, input logic [31:0] id,
			input logic el);
		in_item_t it;
		it.cmd       = c;
		it.window_id = id;
		it.eligible  = el;
		pending_items.push_back(it);
	endfunction

	// Random items mostly reuse a small pool of ids so that focus, query and remove
	// hit entries already in the list; the rest are fresh ids or the empty id.
	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)      it.cmd = CMD_FOCUS;
		else if (pick < 80) it.cmd = CMD_QUERY;
		else if (pick < 96) it.cmd = CMD_REMOVE;
		else                it.cmd = CMD_SPARE;
		pick = $urandom_range(99);
		if (pick < 80)      it.window_id = id_pool[$urandom_range(POOL_SIZE-1)];
		else if (pick < 93) it.window_id = $urandom();
		else                it.window_id = '0;
		it.eligible = ($urandom_range(99) < 85);
		return it;
	endfunction

	// The shadow registers follow the write at once; no items are in flight then.
	task automatic write_reg(input logic [REG_BITS-1:0] idx, input logic [PCT_BITS-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx == REG_LIST_LENGTH || idx == REG_RAMP_START)
			shadow_regs[idx] = 32'(val & 7'h1f);
		else
			shadow_regs[idx] = 32'(val);
		rebuild_ramp();
	endtask

	// Waits until every item has been taken and every predicted result has come back.
	task automatic drain_all();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || predicted_results.size() != 0);
	endtask

	task automatic run_phase(input logic [PCT_BITS-1:0] len, input logic [PCT_BITS-1:0] first,
			input logic [PCT_BITS-1:0] op_lo, input logic [PCT_BITS-1:0] op_hi,
			input logic [PCT_BITS-1:0] br_lo, input logic [PCT_BITS-1:0] br_hi,
			input logic [PCT_BITS-1:0] sa_lo, input logic [PCT_BITS-1:0] sa_hi,
			input int unsigned count, input bit hold);
		write_reg(REG_LIST_LENGTH, len);
		write_reg(REG_RAMP_START, first);
		write_reg(REG_MIN_OPACITY, op_lo);
		write_reg(REG_MAX_OPACITY, op_hi);
		write_reg(REG_MIN_BRIGHT, br_lo);
		write_reg(REG_MAX_BRIGHT, br_hi);
		write_reg(REG_MIN_SAT, sa_lo);
		write_reg(REG_MAX_SAT, sa_hi);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		if (hold) holds_asked++;
		repeat (count) pending_items.push_back(random_item());
		drain_all();
	endtask

	function automatic logic [PCT_BITS-1:0] any_pct();
		return PCT_BITS'($urandom_range(127));
	endfunction

	initial begin
		shadow_regs[REG_LIST_LENGTH] = 32'(RST_LIST_LENGTH);
		shadow_regs[REG_RAMP_START]  = 32'(RST_RAMP_START);
		shadow_regs[REG_MIN_OPACITY] = 32'(RST_MIN_OPACITY);
		shadow_regs[REG_MAX_OPACITY] = 32'(RST_MAX_OPACITY);
		shadow_regs[REG_MIN_BRIGHT]  = 32'(RST_MIN_BRIGHT);
		shadow_regs[REG_MAX_BRIGHT]  = 32'(RST_MAX_BRIGHT);
		shadow_regs[REG_MIN_SAT]     = 32'(RST_MIN_SAT);
		shadow_regs[REG_MAX_SAT]     = 32'(RST_MAX_SAT);
		for (int i = 0; i <= SLOTS; i++) recency[i] = '0;
		rebuild_ramp();

		// The pool always holds the id extremes next to random nonzero ids.
		id_pool[0] = 32'h0000_0001;
		id_pool[1] = 32'hFFFF_FFFF;
		for (int k = 2; k < POOL_SIZE; k++) begin
			id_pool[k] = $urandom();
			if (id_pool[k] == 0) id_pool[k] = k;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items at the reset settings: a list of five with the ramp from
		// the front. They walk through the empty id, an ineligible focus, filling
		// the list until an entry drops off, focus of the front and of a middle
		// entry, the unused command code, and removal of present and absent ids.
		send_gap_pct   = 11;
		recv_stall_pct = 49;
		offer(CMD_QUERY,  32'h0000_0000, 1'b1);
		offer(CMD_FOCUS,  32'h0000_0000, 1'b1);
		offer(CMD_REMOVE, 32'h0000_0000, 1'b1);
		offer(CMD_FOCUS,  32'h0000_0001, 1'b0);
		offer(CMD_FOCUS,  32'h0000_0001, 1'b1);
		offer(CMD_FOCUS,  32'h8000_0000, 1'b1);
		offer(CMD_FOCUS,  32'hFFFF_FFFF, 1'b1);
		offer(CMD_FOCUS,  32'h1234_5678, 1'b1);
		offer(CMD_FOCUS,  32'hA5A5_5A5A, 1'b1);
		offer(CMD_FOCUS,  32'h0F0F_F0F0, 1'b1);
		offer(CMD_QUERY,  32'h0000_0001, 1'b1);
		offer(CMD_FOCUS,  32'h0F0F_F0F0, 1'b1);
		offer(CMD_FOCUS,  32'hFFFF_FFFF, 1'b1);
		offer(CMD_SPARE,  32'hFFFF_FFFF, 1'b1);
		offer(CMD_QUERY,  32'h1234_5678, 1'b0);
		offer(CMD_REMOVE, 32'h0F0F_F0F0, 1'b1);
		offer(CMD_REMOVE, 32'h0F0F_F0F0, 1'b0);
		offer(CMD_FOCUS,  32'h0000_0001, 1'b1);
		offer(CMD_FOCUS,  32'h8000_0000, 1'b1);
		offer(CMD_QUERY,  32'h8000_0000, 1'b1);
		offer(CMD_QUERY,  32'hA5A5_5A5A, 1'b1);
		offer(CMD_REMOVE, 32'hFFFF_FFFF, 1'b1);
		offer(CMD_QUERY,  32'h1234_5678, 1'b1);
		offer(CMD_REMOVE, 32'h8000_0000, 1'b0);
		offer(CMD_QUERY,  32'h0000_0000, 1'b0);
		drain_all();

		// Sender rarely idles, receiver stalls about half the time. The first phase
		// also blocks the output long enough for the input to back up. Length and
		// ramp start sweep their extremes, including values the block clamps and
		// percents above a hundred.
		run_phase(7'd16, 7'd1, 7'd0, 7'd100, 7'd100, 7'd0, 7'd50, 7'd50, 200, 1'b1);
		run_phase(7'h7f, 7'd0, 7'd127, 7'd127, 7'd101, 7'd0, 7'd0, 7'd0, 120, 1'b0);
		run_phase(7'd1, 7'd16, 7'd30, 7'd60, 7'd60, 7'd30, 7'd127, 7'd100, 100, 1'b0);

		// Now the sender idles about half the time and the receiver rarely stalls.
		// The shorter lists leave stale entries behind that reappear on growth.
		send_gap_pct   = 49;
		recv_stall_pct = 11;
		run_phase(7'd3, 7'd2, any_pct(), any_pct(), any_pct(), any_pct(), any_pct(),
			any_pct(), 140, 1'b0);
		run_phase(7'd0, 7'd31, any_pct(), any_pct(), any_pct(), any_pct(), any_pct(),
			any_pct(), 80, 1'b0);
		run_phase(7'd16, 7'd16, 7'd0, 7'd100, 7'd0, 7'd100, 7'd0, 7'd100, 180, 1'b0);
		// Only the low five bits of the length register are kept.
		run_phase(7'h65, 7'd3, any_pct(), any_pct(), any_pct(), any_pct(), any_pct(),
			any_pct(), 120, 1'b0);

		// Full rate on both sides, with one more long output block.
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		run_phase(7'd8, 7'd5, any_pct(), any_pct(), any_pct(), any_pct(), any_pct(),
			any_pct(), 150, 1'b1);
		run_phase(PCT_BITS'($urandom_range(20)), PCT_BITS'($urandom_range(20)), any_pct(),
			any_pct(), any_pct(), any_pct(), any_pct(), any_pct(), 150, 1'b0);
		run_phase(7'd16, 7'd9, 7'd100, 7'd0, 7'd0, 7'd100, 7'd100, 7'd0, 150, 1'b0);

		// Let any stray result surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predicted_results.size() != 0)
			log_mismatch("results never arrived", 32'(predicted_results.size()), '0);
		if (mismatches == 0) begin
			$display("PASS recency_stack_attribute_ramp_top");
		end else begin
			$display("FAIL recency_stack_attribute_ramp_top");
		end
		$finish;
	end

endmodule
